// File: design/disk_thermal_monitor_top_macros.svh
// Assertion macros shared by the disk thermal monitor RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef DISK_THERMAL_MONITOR_TOP_MACROS_SVH
`define DISK_THERMAL_MONITOR_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset
`define DTM_ASSERT_IMP(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define DTM_ASSERT_NXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/dtm_pkg.sv
// Shared types and constants for the disk thermal monitor.
// No dependencies; referenced by scoped name from the top and the slot engine, imported by the testbench.
package dtm_pkg;

  // Table and series sizes
  localparam int DEVICES = 16;
  localparam int SAMPLES = 32;
  localparam int DEV_AW  = (DEVICES > 1) ? $clog2(DEVICES) : 1;
  localparam int CNT_W   = $clog2(SAMPLES);

  // Field widths
  localparam int ID_W       = 64;
  localparam int RAW_W      = 64;
  localparam int TIME_W     = 32;
  localparam int TEMP_W     = 7;
  localparam int LIMIT_W    = 8;
  localparam int SLOT_W     = 4;
  localparam int PIDX_W     = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [TEMP_W-1:0] TEMP_CEILING   = 7'd100;
  localparam logic [RAW_W-1:0]  RAW_UNASSIGNED = '1;

  // Configuration register indexes
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_TEMP_LIMIT   = 2'd0;
  localparam cfg_idx_t REG_GATHER_STOP  = 2'd1;
  localparam cfg_idx_t REG_AMBIENT_SEED = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SLOT,
    ST_DONE
  } top_state_t;

  typedef enum logic [1:0] {
    EN_IDLE,
    EN_SEARCH,
    EN_RECRD,
    EN_UPD
  } eng_state_t;

  // Per-slot record kept in the record memory
  typedef struct packed {
    logic [TEMP_W-1:0] latest;
    logic [CNT_W-1:0]  count;
    logic [TEMP_W-1:0] last_point;
  } rec_t;

  // Request from the top level to the slot engine
  typedef struct packed {
    logic [ID_W-1:0]   device_id;
    logic [TEMP_W-1:0] temp;
    logic [TIME_W-1:0] when;
    logic              gather_off;
  } slot_req_t;

  // Slot engine result
  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic              full;
    logic              appended;
    logic [PIDX_W-1:0] index;
    logic [TEMP_W-1:0] ptemp;
    logic [TIME_W-1:0] ptime;
  } slot_res_t;

endpackage

// File: design/disk_thermal_monitor_top.sv
// Each input item is taken in ST_IDLE. A disabled monitor or an invalid reading goes straight
// to ST_DONE; a valid reading first passes through the slot engine search (ST_SLOT). A new
// item is taken only after the previous result has entered the output register, which
// waits in ST_DONE for the receiver; the slot search makes one device-table memory read
// per cycle. Synchronous active-high reset clears control state, the slot
// used bits, the scan state and the configuration registers.
module disk_thermal_monitor_top (
  input  logic                            clk,
  input  logic                            rst,
  // input items
  input  logic                            item_valid,
  output logic                            item_ready,
  input  logic [dtm_pkg::ID_W-1:0]        device_id,
  input  logic [dtm_pkg::RAW_W-1:0]       raw_temperature,
  input  logic [dtm_pkg::TIME_W-1:0]      elapsed_time,
  input  logic                            last_of_scan,
  // results
  output logic                            result_valid,
  input  logic                            result_ready,
  output logic                            reading_valid,
  output logic [dtm_pkg::SLOT_W-1:0]      slot,
  output logic                            table_full,
  output logic                            point_appended,
  output logic [dtm_pkg::PIDX_W-1:0]      point_index,
  output logic [dtm_pkg::TEMP_W-1:0]      point_temperature,
  output logic [dtm_pkg::TIME_W-1:0]      point_time,
  output logic                            scan_done,
  output logic [dtm_pkg::TEMP_W-1:0]      peak_temperature,
  output logic                            over_limit,
  output logic [dtm_pkg::TEMP_W-1:0]      ambient_level,
  output logic                            ambient_over_limit,
  // configuration writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [dtm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dtm_pkg::CFG_DATA_W-1:0]  cfg_data
);

  dtm_pkg::top_state_t state, state_next;

  // configuration
  logic [dtm_pkg::LIMIT_W-1:0] temp_limit;
  logic                        gather_stop;
  logic [dtm_pkg::TEMP_W-1:0]  amb_seed;

  // scan state
  logic [dtm_pkg::TEMP_W-1:0]  ambient;
  logic                        deriving;
  logic                        in_scan;
  logic [dtm_pkg::TEMP_W-1:0]  scan_highest;
  logic [dtm_pkg::TEMP_W-1:0]  highest;

  // pending result
  logic                        pend_rd;
  logic                        pend_done;
  logic                        pend_over;
  logic                        pend_aover;
  logic [dtm_pkg::TEMP_W-1:0]  pend_amb;
  dtm_pkg::slot_res_t          pend_res;

  logic                        accept;
  logic                        enabled;
  logic                        rd_ok;
  logic [dtm_pkg::TEMP_W-1:0]  t;
  logic [dtm_pkg::TEMP_W-1:0]  seed_clip;
  logic [dtm_pkg::TEMP_W-1:0]  amb_a, amb_b;
  logic                        der_a;
  logic [dtm_pkg::TEMP_W-1:0]  sh_a, sh_b;
  logic                        start;
  logic                        load_out;
  dtm_pkg::slot_req_t          req;
  logic                        eng_done;
  dtm_pkg::slot_res_t          eng_res;

  assign cfg_ready = 1'b1;
  assign accept    = item_valid && item_ready;
  assign enabled   = (temp_limit != '0);
  assign rd_ok     = (raw_temperature != dtm_pkg::RAW_UNASSIGNED)
                     && (raw_temperature != '0)
                     && (raw_temperature <= dtm_pkg::RAW_W'(dtm_pkg::TEMP_CEILING));
  assign t         = raw_temperature[dtm_pkg::TEMP_W-1:0];
  assign seed_clip = (amb_seed > dtm_pkg::TEMP_CEILING) ? dtm_pkg::TEMP_CEILING : amb_seed;
  assign start     = accept && enabled && rd_ok;

  // Scan opening, ambient derivation and scan maximum for the item at the port
  always_comb begin
    amb_a = ambient;
    der_a = deriving;
    sh_a  = scan_highest;
    if (!in_scan) begin
      sh_a = '0;
      if (ambient == '0) begin
        amb_a = seed_clip;
        der_a = 1'b1;
      end
    end
    amb_b = amb_a;
    sh_b  = sh_a;
    if (rd_ok) begin
      if (der_a && ((amb_a == '0) || (amb_a > t))) begin
        amb_b = t;
      end
      if (sh_a < t) begin
        sh_b = t;
      end
    end
  end

  always_comb begin
    req.device_id  = device_id;
    req.temp       = t;
    req.when       = elapsed_time;
    req.gather_off = gather_stop;
  end

  dtm_slot u_slot (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .req   (req),
    .done  (eng_done),
    .res   (eng_res)
  );

  // Sequencer
  always_comb begin
    state_next = state;
    item_ready = 1'b0;
    load_out   = 1'b0;
    case (state)
      dtm_pkg::ST_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          state_next = start ? dtm_pkg::ST_SLOT : dtm_pkg::ST_DONE;
        end
      end
      dtm_pkg::ST_SLOT: begin
        if (eng_done) begin
          state_next = dtm_pkg::ST_DONE;
        end
      end
      dtm_pkg::ST_DONE: begin
        if (!result_valid || result_ready) begin
          load_out   = 1'b1;
          state_next = dtm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = dtm_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dtm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      temp_limit  <= '0;
      gather_stop <= 1'b0;
      amb_seed    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        dtm_pkg::REG_TEMP_LIMIT:   temp_limit  <= cfg_data;
        dtm_pkg::REG_GATHER_STOP:  gather_stop <= cfg_data[0];
        dtm_pkg::REG_AMBIENT_SEED: amb_seed    <= cfg_data[dtm_pkg::TEMP_W-1:0];
        default: ;
      endcase
    end
  end

  // Scan state update on each transfer while enabled
  always_ff @(posedge clk) begin
    if (rst) begin
      ambient      <= '0;
      deriving     <= 1'b0;
      in_scan      <= 1'b0;
      scan_highest <= '0;
      highest      <= '0;
    end else if (accept && enabled) begin
      ambient      <= amb_b;
      deriving     <= last_of_scan ? 1'b0 : der_a;
      in_scan      <= !last_of_scan;
      scan_highest <= sh_b;
      if (last_of_scan) begin
        highest <= sh_b;
      end
    end
  end

  // Pending result fields
  always_ff @(posedge clk) begin
    if (accept) begin
      pend_rd    <= enabled && rd_ok;
      pend_done  <= enabled && last_of_scan;
      pend_over  <= enabled && last_of_scan && ({1'b0, sh_b} > temp_limit);
      pend_aover <= enabled && last_of_scan && (amb_b != '0)
                    && (temp_limit <= {1'b0, amb_b});
      pend_amb   <= enabled ? amb_b : '0;
      pend_res   <= '0;
    end
    if ((state == dtm_pkg::ST_SLOT) && eng_done) begin
      pend_res <= eng_res;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_out) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      reading_valid      <= pend_rd;
      slot               <= pend_res.slot;
      table_full         <= pend_res.full;
      point_appended     <= pend_res.appended;
      point_index        <= pend_res.index;
      point_temperature  <= pend_res.ptemp;
      point_time         <= pend_res.ptime;
      scan_done          <= pend_done;
      peak_temperature   <= pend_done ? highest : '0;
      over_limit         <= pend_over;
      ambient_level      <= pend_amb;
      ambient_over_limit <= pend_aover;
    end
  end

endmodule

// File: design/dtm_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module dtm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/dtm_slot.sv
// Slot engine: sequential device-table search, slot allocation and
// heating-point record update. Uses dtm_pkg, dtm_ram and the assertion macros.
`include "disk_thermal_monitor_top_macros.svh"

module dtm_slot (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  dtm_pkg::slot_req_t req,
  output logic              done,
  output dtm_pkg::slot_res_t res
);

  dtm_pkg::eng_state_t state, state_next;

  logic [dtm_pkg::DEVICES-1:0] used;
  dtm_pkg::slot_req_t          req_q;
  logic [dtm_pkg::DEV_AW-1:0]  cnt;
  logic [dtm_pkg::DEV_AW-1:0]  chk_idx;
  logic [dtm_pkg::DEV_AW-1:0]  slot_q;
  logic                        chk_vld;
  logic                        fresh;
  dtm_pkg::slot_res_t          res_q;
  logic                        done_q;

  logic                        dev_we;
  logic [dtm_pkg::ID_W-1:0]    dev_rdata;
  logic                        rec_we;
  logic [$bits(dtm_pkg::rec_t)-1:0] rec_rdata;
  logic [$bits(dtm_pkg::rec_t)-1:0] rec_wdata;

  logic                        free_any;
  logic [dtm_pkg::DEV_AW-1:0]  free_idx;
  logic                        hit;
  logic                        last_chk;
  logic                        finish;
  logic                        fin_full;
  dtm_pkg::rec_t               rec;
  dtm_pkg::rec_t               rec_new;
  logic [dtm_pkg::CNT_W:0]     cnt_plus;
  logic                        append;

  // Device id memory, scanned one entry per cycle
  dtm_ram #(
    .WIDTH (dtm_pkg::ID_W),
    .DEPTH (dtm_pkg::DEVICES),
    .AW    (dtm_pkg::DEV_AW)
  ) u_dev_ram (
    .clk   (clk),
    .we    (dev_we),
    .waddr (free_idx),
    .wdata (req_q.device_id),
    .raddr (cnt),
    .rdata (dev_rdata)
  );

  // Per-slot record memory, read-modify-write at the chosen slot
  dtm_ram #(
    .WIDTH ($bits(dtm_pkg::rec_t)),
    .DEPTH (dtm_pkg::DEVICES),
    .AW    (dtm_pkg::DEV_AW)
  ) u_rec_ram (
    .clk   (clk),
    .we    (rec_we),
    .waddr (slot_q),
    .wdata (rec_wdata),
    .raddr (slot_q),
    .rdata (rec_rdata)
  );

  // Lowest free slot
  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = dtm_pkg::DEVICES - 1; i >= 0; i--) begin
      if (!used[i]) begin
        free_any = 1'b1;
        free_idx = dtm_pkg::DEV_AW'(i);
      end
    end
  end

  assign hit      = chk_vld && used[chk_idx] && (dev_rdata == req_q.device_id);
  assign last_chk = (chk_idx == dtm_pkg::DEV_AW'(dtm_pkg::DEVICES - 1));

  // Record update: a freshly taken slot starts from an empty series
  always_comb begin
    rec      = fresh ? '0 : dtm_pkg::rec_t'(rec_rdata);
    cnt_plus = {1'b0, rec.count} + (dtm_pkg::CNT_W + 1)'(1);
    append   = !req_q.gather_off
               && (cnt_plus < (dtm_pkg::CNT_W + 1)'(dtm_pkg::SAMPLES))
               && ((rec.count == '0) || (rec.last_point < req_q.temp));
    rec_new.latest     = req_q.temp;
    rec_new.count      = append ? cnt_plus[dtm_pkg::CNT_W-1:0] : rec.count;
    rec_new.last_point = append ? req_q.temp : rec.last_point;
    rec_wdata          = rec_new;
  end

  // Next state and strobes
  always_comb begin
    state_next = state;
    dev_we     = 1'b0;
    rec_we     = 1'b0;
    finish     = 1'b0;
    fin_full   = 1'b0;
    case (state)
      dtm_pkg::EN_IDLE: begin
        if (start) begin
          state_next = dtm_pkg::EN_SEARCH;
        end
      end
      dtm_pkg::EN_SEARCH: begin
        if (hit) begin
          state_next = dtm_pkg::EN_RECRD;
        end else if (chk_vld && last_chk) begin
          if (free_any) begin
            dev_we     = 1'b1;
            state_next = dtm_pkg::EN_UPD;
          end else begin
            finish     = 1'b1;
            fin_full   = 1'b1;
            state_next = dtm_pkg::EN_IDLE;
          end
        end
      end
      dtm_pkg::EN_RECRD: begin
        state_next = dtm_pkg::EN_UPD;
      end
      dtm_pkg::EN_UPD: begin
        rec_we     = 1'b1;
        finish     = 1'b1;
        state_next = dtm_pkg::EN_IDLE;
      end
      default: begin
        state_next = dtm_pkg::EN_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= dtm_pkg::EN_IDLE;
      used    <= '0;
      chk_vld <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state   <= state_next;
      chk_vld <= (state == dtm_pkg::EN_SEARCH) && (state_next == dtm_pkg::EN_SEARCH);
      done_q  <= finish;
      if (dev_we) begin
        used[free_idx] <= 1'b1;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if ((state == dtm_pkg::EN_IDLE) && start) begin
      req_q <= req;
      cnt   <= '0;
      fresh <= 1'b0;
    end
    if (state == dtm_pkg::EN_SEARCH) begin
      chk_idx <= cnt;
      if (cnt != dtm_pkg::DEV_AW'(dtm_pkg::DEVICES - 1)) begin
        cnt <= cnt + dtm_pkg::DEV_AW'(1);
      end
    end
    if (hit) begin
      slot_q <= chk_idx;
    end
    if (dev_we) begin
      slot_q <= free_idx;
      fresh  <= 1'b1;
    end
    // Table full: slot and point fields read as zero
    if (fin_full) begin
      res_q.slot     <= '0;
      res_q.full     <= 1'b1;
      res_q.appended <= 1'b0;
      res_q.index    <= '0;
      res_q.ptemp    <= '0;
      res_q.ptime    <= '0;
    end
    if (rec_we) begin
      res_q.slot     <= dtm_pkg::SLOT_W'(slot_q);
      res_q.full     <= 1'b0;
      res_q.appended <= append;
      res_q.index    <= append ? dtm_pkg::PIDX_W'(rec.count) : '0;
      res_q.ptemp    <= append ? req_q.temp : '0;
      res_q.ptime    <= append ? req_q.when : '0;
    end
  end

  assign done = done_q;
  assign res  = res_q;

  // Checks
  `DTM_ASSERT_IMP(a_upd_slot_used, clk, rst, state == dtm_pkg::EN_UPD, used[slot_q], "record update on a slot not in use")
  `DTM_ASSERT_IMP(a_full_no_point, clk, rst, done_q, !(res_q.full && res_q.appended), "point appended with table full")
  `DTM_ASSERT_NXT(a_alloc_to_upd, clk, rst, dev_we, (state == dtm_pkg::EN_UPD) && fresh, "allocation not followed by fresh update")

endmodule

// File: verif/disk_thermal_monitor_top_test.sv
// Self-checking testbench for disk_thermal_monitor_top: drives readings and register writes,
// predicts every result and checks it. Depends on dtm_pkg and the RTL under design/.
`timescale 1ns / 1ps

module disk_thermal_monitor_top_test;
  import dtm_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 30;
  // index with no register behind it
  localparam cfg_idx_t REG_SPARE = 2'd3;

  typedef struct packed {
    logic              reading_valid;
    logic [SLOT_W-1:0] slot;
    logic              table_full;
    logic              point_appended;
    logic [PIDX_W-1:0] point_index;
    logic [TEMP_W-1:0] point_temperature;
    logic [TIME_W-1:0] point_time;
    logic              scan_done;
    logic [TEMP_W-1:0] peak_temperature;
    logic              over_limit;
    logic [TEMP_W-1:0] ambient_level;
    logic              ambient_over_limit;
  } thermal_report_t;

  typedef enum {READY_ALWAYS, READY_HALF, READY_MOSTLY, READY_SPARSE} ready_pattern_t;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  item_valid = 1'b0;
  logic                  item_ready;
  logic [ID_W-1:0]       device_id = '0;
  logic [RAW_W-1:0]      raw_temperature = '0;
  logic [TIME_W-1:0]     elapsed_time = '0;
  logic                  last_of_scan = 1'b0;
  logic                  result_valid;
  logic                  result_ready = 1'b0;
  logic                  reading_valid;
  logic [SLOT_W-1:0]     slot;
  logic                  table_full;
  logic                  point_appended;
  logic [PIDX_W-1:0]     point_index;
  logic [TEMP_W-1:0]     point_temperature;
  logic [TIME_W-1:0]     point_time;
  logic                  scan_done;
  logic [TEMP_W-1:0]     peak_temperature;
  logic                  over_limit;
  logic [TEMP_W-1:0]     ambient_level;
  logic                  ambient_over_limit;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  cfg_idx_t              cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  disk_thermal_monitor_top dut (.*);

  // Predicted device table and scan state
  logic [ID_W-1:0]    table_id [DEVICES];
  bit                 table_used [DEVICES];
  logic [TEMP_W-1:0]  table_latest [DEVICES];
  int                 table_points [DEVICES];
  logic [TEMP_W-1:0]  table_last_point [DEVICES];
  logic [TEMP_W-1:0]  ambient_est = '0;
  bit                 deriving_amb = 1'b0;
  bit                 scan_open = 1'b0;
  logic [TEMP_W-1:0]  scan_max = '0;
  logic [TEMP_W-1:0]  last_scan_max = '0;
  // Predicted register contents
  logic [LIMIT_W-1:0] alarm_limit = '0;
  bit                 gather_off = 1'b0;
  logic [TEMP_W-1:0]  seed_est = '0;

  thermal_report_t expected_reports[$];
  int  mismatches = 0;
  int  cycle_count = 0;
  int  burst_left = 0;
  bit  steady_sender = 1'b0;
  bit  hold_request = 1'b0;
  int  hold_left = 0;
  int  stretch_left = 0;
  ready_pattern_t ready_pattern = READY_ALWAYS;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Run-length guard
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("disk_thermal_monitor_top test failed");
      $finish;
    end
  end

  // Expected result of one reading; updates the predicted state
  function automatic thermal_report_t predict_report(logic [ID_W-1:0] id,
                                                     logic [RAW_W-1:0] raw,
                                                     logic [TIME_W-1:0] stamp,
                                                     logic closes);
    thermal_report_t r;
    logic [TEMP_W-1:0] t;
    int k;
    int hit;
    r = '0;
    if (alarm_limit == 0) return r;

    // opening a scan
    if (!scan_open) begin
      scan_open = 1'b1;
      scan_max = '0;
      if (ambient_est == 0) begin
        ambient_est = (seed_est > TEMP_CEILING) ? TEMP_CEILING : seed_est;
        deriving_amb = 1'b1;
      end
    end

    if (raw != RAW_UNASSIGNED && raw != 0 && raw <= TEMP_CEILING) begin
      t = raw[TEMP_W-1:0];
      r.reading_valid = 1'b1;
      if (deriving_amb && (ambient_est == 0 || ambient_est > t)) ambient_est = t;
      if (scan_max < t) scan_max = t;

      // known drive first, else the lowest free slot
      hit = -1;
      for (k = 0; k < DEVICES; k++)
        if (hit < 0 && table_used[k] && table_id[k] == id) hit = k;
      for (k = 0; k < DEVICES; k++) begin
        if (hit < 0 && !table_used[k]) begin
          table_used[k] = 1'b1;
          table_id[k] = id;
          table_points[k] = 0;
          table_last_point[k] = '0;
          table_latest[k] = '0;
          hit = k;
        end
      end

      if (hit < 0) begin
        r.table_full = 1'b1;
      end else begin
        r.slot = SLOT_W'(hit);
        table_latest[hit] = t;
        if (!gather_off && table_points[hit] + 1 < SAMPLES &&
            (table_points[hit] == 0 || table_last_point[hit] < t)) begin
          r.point_appended = 1'b1;
          r.point_index = PIDX_W'(table_points[hit]);
          r.point_temperature = t;
          r.point_time = stamp;
          table_last_point[hit] = t;
          table_points[hit]++;
        end
      end
    end

    if (closes) begin
      last_scan_max = scan_max;
      r.scan_done = 1'b1;
      r.peak_temperature = last_scan_max;
      r.over_limit = last_scan_max > alarm_limit;
      r.ambient_over_limit = ambient_est != 0 && alarm_limit <= ambient_est;
      scan_open = 1'b0;
      deriving_amb = 1'b0;
    end
    r.ambient_level = ambient_est;
    return r;
  endfunction

  task automatic note_failure(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t: %s", $time, msg);
  endtask

  // Result checker: each result transfer against the oldest expectation
  always @(posedge clk) begin
    thermal_report_t seen;
    thermal_report_t want;
    string d;
    if (!rst && result_valid && result_ready) begin
      seen = '{reading_valid, slot, table_full, point_appended, point_index,
               point_temperature, point_time, scan_done, peak_temperature,
               over_limit, ambient_level, ambient_over_limit};
      if (expected_reports.size() == 0) begin
        note_failure($sformatf("result with nothing expected: %p", seen));
      end else begin
        want = expected_reports.pop_front();
        d = "";
        if (want.reading_valid !== seen.reading_valid)
          d = {d, $sformatf(" reading_valid exp %0d got %0d", want.reading_valid,
                            seen.reading_valid)};
        if (want.slot !== seen.slot)
          d = {d, $sformatf(" slot exp %0d got %0d", want.slot, seen.slot)};
        if (want.table_full !== seen.table_full)
          d = {d, $sformatf(" table_full exp %0d got %0d", want.table_full, seen.table_full)};
        if (want.point_appended !== seen.point_appended)
          d = {d, $sformatf(" point_appended exp %0d got %0d", want.point_appended,
                            seen.point_appended)};
        if (want.point_index !== seen.point_index)
          d = {d, $sformatf(" point_index exp %0d got %0d", want.point_index,
                            seen.point_index)};
        if (want.point_temperature !== seen.point_temperature)
          d = {d, $sformatf(" point_temperature exp %0d got %0d", want.point_temperature,
                            seen.point_temperature)};
        if (want.point_time !== seen.point_time)
          d = {d, $sformatf(" point_time exp %0d got %0d", want.point_time, seen.point_time)};
        if (want.scan_done !== seen.scan_done)
          d = {d, $sformatf(" scan_done exp %0d got %0d", want.scan_done, seen.scan_done)};
        if (want.peak_temperature !== seen.peak_temperature)
          d = {d, $sformatf(" peak_temperature exp %0d got %0d",
                            want.peak_temperature, seen.peak_temperature)};
        if (want.over_limit !== seen.over_limit)
          d = {d, $sformatf(" over_limit exp %0d got %0d", want.over_limit, seen.over_limit)};
        if (want.ambient_level !== seen.ambient_level)
          d = {d, $sformatf(" ambient_level exp %0d got %0d",
                            want.ambient_level, seen.ambient_level)};
        if (want.ambient_over_limit !== seen.ambient_over_limit)
          d = {d, $sformatf(" ambient_over_limit exp %0d got %0d",
                            want.ambient_over_limit, seen.ambient_over_limit)};
        if (d != "") note_failure({"result mismatch:", d});
      end
    end
  end

  // Result-side ready: long hold-off on request, else patterns in stretches
  always @(negedge clk) begin
    if (hold_request) begin
      hold_left = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      result_ready <= 1'b0;
    end else begin
      if (stretch_left == 0) begin
        ready_pattern = ready_pattern_t'($urandom_range(0, 3));
        stretch_left = $urandom_range(10, 150);
      end
      stretch_left--;
      case (ready_pattern)
        READY_ALWAYS: result_ready <= 1'b1;
        READY_HALF:   result_ready <= ($urandom_range(0, 1) == 0);
        READY_MOSTLY: result_ready <= ($urandom_range(0, 3) != 0);
        default:      result_ready <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  // Offer one reading and wait for its transfer; called and returns at a falling edge
  task automatic send_reading(input logic [ID_W-1:0] id, input logic [RAW_W-1:0] raw,
                              input logic [TIME_W-1:0] stamp, input logic closes);
    int gap;
    if (burst_left == 0) begin
      gap = steady_sender ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        item_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 10);
    end
    burst_left--;
    item_valid <= 1'b1;
    device_id <= id;
    raw_temperature <= raw;
    elapsed_time <= stamp;
    last_of_scan <= closes;
    do @(posedge clk); while (!item_ready);
    expected_reports.push_back(predict_report(id, raw, stamp, closes));
    @(negedge clk);
  endtask

  // Stop offering and wait for every outstanding result
  task automatic wait_idle();
    item_valid <= 1'b0;
    do @(negedge clk); while (expected_reports.size() != 0);
  endtask

  task automatic write_register(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_TEMP_LIMIT:   alarm_limit = data;
      REG_GATHER_STOP:  gather_off = data[0];
      REG_AMBIENT_SEED: seed_est = data[TEMP_W-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  // Registers change only with the block drained
  task automatic program_registers(input logic [CFG_DATA_W-1:0] limit_val,
                                   input logic [CFG_DATA_W-1:0] gather_val,
                                   input logic [CFG_DATA_W-1:0] seed_val,
                                   input bit touch_spare);
    wait_idle();
    write_register(REG_TEMP_LIMIT, limit_val);
    write_register(REG_GATHER_STOP, gather_val);
    write_register(REG_AMBIENT_SEED, seed_val);
    if (touch_spare) write_register(REG_SPARE, CFG_DATA_W'($urandom));
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [ID_W-1:0] pick_device();
    int k = $urandom_range(0, DEVICES - 1);
    if (table_used[k] && $urandom_range(0, 4) != 0) return table_id[k];
    return {$urandom, $urandom};
  endfunction

  // Mostly valid temperatures, with the invalid encodings mixed in
  function automatic logic [RAW_W-1:0] pick_raw();
    case ($urandom_range(0, 9))
      0: return {$urandom, $urandom};
      1: return RAW_UNASSIGNED;
      2: return ($urandom_range(0, 1) == 0) ? '0 : RAW_W'($urandom_range(101, 255));
      3: return ($urandom_range(0, 1) == 0) ? RAW_W'(1) : RAW_W'(TEMP_CEILING);
      default: return RAW_W'($urandom_range(1, 100));
    endcase
  endfunction

  // Limit zero: block ignores everything
  task automatic test_disabled();
    send_reading('0, 64'd50, '0, 1'b0);
    send_reading('1, RAW_UNASSIGNED, '1, 1'b0);
    send_reading('0, 64'd30, 32'd7, 1'b1);
  endtask

  // Unassigned, zero and out-of-range values; scan with no valid reading, ambient unknown
  task automatic test_invalid_readings();
    program_registers(8'd50, 8'h00, 8'h00, 1'b0);
    send_reading('0, RAW_UNASSIGNED, '0, 1'b0);
    send_reading('0, '0, '1, 1'b0);
    send_reading('1, 64'd101, 32'd3, 1'b0);
    send_reading('1, 64'h8000_0000_0000_0032, 32'd4, 1'b0);
    send_reading(64'h5A5A_A5A5_0F0F_F0F0, 64'h0000_0001_0000_0000, 32'd5, 1'b1);
  endtask

  // Seed above the ceiling, ambient lowered while deriving, then frozen next scan
  task automatic test_ambient_derivation();
    program_registers(8'd50, 8'h00, 8'hFF, 1'b0);
    send_reading('0, 64'd100, 32'd10, 1'b0);
    send_reading('0, 64'd1, 32'd11, 1'b0);
    send_reading('1, 64'd60, 32'd12, 1'b0);
    send_reading('0, 64'd100, 32'd13, 1'b0);
    send_reading('1, 64'd70, 32'd14, 1'b1);
    send_reading(64'h5A5A_A5A5_0F0F_F0F0, 64'd30, 32'd20, 1'b0);
    send_reading('1, 64'd20, 32'd21, 1'b0);
    send_reading('0, 64'd99, 32'd22, 1'b1);
  endtask

  // Limit extremes against the ambient, and appending held off by gathering stop
  task automatic test_limits_and_gathering();
    program_registers(8'd1, 8'h00, 8'h00, 1'b0);
    send_reading(64'h5A5A_A5A5_0F0F_F0F0, 64'd1, 32'd30, 1'b1);
    program_registers(8'd255, 8'hFE, 8'h80, 1'b0);
    send_reading('0, 64'd100, 32'd31, 1'b1);
    program_registers(8'd40, 8'h01, 8'h00, 1'b0);
    send_reading('1, 64'd90, 32'd32, 1'b0);
    send_reading(64'h5A5A_A5A5_0F0F_F0F0, 64'd95, 32'd33, 1'b1);
    program_registers(8'd40, 8'h00, 8'h00, 1'b0);
    send_reading(64'h5A5A_A5A5_0F0F_F0F0, 64'd96, '1, 1'b1);
  endtask

  // Steadily heating drives fill their series and run past its end
  task automatic test_series_full();
    logic [ID_W-1:0]   ids [4];
    logic [TEMP_W-1:0] level [4];
    int s;
    int d;
    program_registers(8'd60, {7'($urandom), 1'b0}, CFG_DATA_W'($urandom), 1'b0);
    for (d = 0; d < 4; d++) begin
      ids[d] = {$urandom, $urandom};
      level[d] = TEMP_W'($urandom_range(2, 6));
    end
    for (s = 0; s < 36; s++) begin
      for (d = 0; d < 4; d++) begin
        send_reading(ids[d], RAW_W'(level[d]), $urandom, d == 3);
        level[d] += TEMP_W'($urandom_range(1, 2));
      end
    end
  endtask

  // New drives until the table overflows, then a known drive
  task automatic test_table_full();
    int k;
    int free_slots;
    program_registers(CFG_DATA_W'($urandom_range(1, 255)), {7'($urandom), 1'b0},
                      CFG_DATA_W'($urandom), 1'b0);
    free_slots = 0;
    for (k = 0; k < DEVICES; k++)
      if (!table_used[k]) free_slots++;
    repeat (free_slots + 3)
      send_reading({$urandom, $urandom}, RAW_W'($urandom_range(1, 100)), $urandom, 1'b0);
    send_reading(table_id[0], RAW_W'($urandom_range(1, 100)), $urandom, 1'b1);
  endtask

  // Receiver holds off for a long stretch while readings keep coming
  task automatic test_backpressure();
    wait_idle();
    steady_sender = 1'b1;
    hold_request = 1'b1;
    repeat (16) send_reading(pick_device(), pick_raw(), $urandom, $urandom_range(0, 3) == 0);
    steady_sender = 1'b0;
    wait_idle();
  endtask

  // Mixed traffic over several register settings
  task automatic test_random_traffic();
    int phase;
    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        0: program_registers(8'd255, {7'($urandom), 1'b0}, CFG_DATA_W'($urandom), 1'b1);
        1: program_registers(8'd0, CFG_DATA_W'($urandom), CFG_DATA_W'($urandom), 1'b0);
        2: program_registers(CFG_DATA_W'($urandom_range(1, 254)), {7'($urandom), 1'b1},
                             CFG_DATA_W'($urandom), 1'b0);
        default: program_registers(CFG_DATA_W'($urandom_range(1, 100)),
                                   {7'($urandom), 1'($urandom_range(0, 3) == 0)},
                                   CFG_DATA_W'($urandom), 1'b0);
      endcase
      steady_sender = ($urandom_range(0, 3) == 0);
      repeat (50) send_reading(pick_device(), pick_raw(), $urandom, $urandom_range(0, 5) == 0);
    end
    steady_sender = 1'b0;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_disabled();
    test_invalid_readings();
    test_ambient_derivation();
    test_limits_and_gathering();
    test_series_full();
    test_table_full();
    test_backpressure();
    test_random_traffic();

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_reports.size() == 0)
      $display("disk_thermal_monitor_top test passed");
    else
      $display("disk_thermal_monitor_top test failed");
    $finish;
  end

endmodule
